// ----- rtl/icmp_rcrm_pkg.sv -----
`timescale 1ns / 1ps

package icmp_rcrm_pkg;

  // pending reply ring
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ENTRY_W     = 64;

  // field widths
  localparam int ACT_W  = 2;
  localparam int LEN_W  = 12;
  localparam int TYPE_W = 8;
  localparam int ID_W   = 16;
  localparam int SEQ_W  = 16;
  localparam int IP_W   = 32;
  localparam int RLEN_W = 10;
  localparam int CNT_W  = 32;

  localparam int IN_FIELDS_W  = LEN_W + TYPE_W + ID_W + SEQ_W + IP_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

  // statistics counters
  localparam int N_CNT     = 7;
  localparam int CNT_IDX_W = 3;
  localparam logic [CNT_IDX_W-1:0] C_RX      = 3'd0;
  localparam logic [CNT_IDX_W-1:0] C_TX      = 3'd1;
  localparam logic [CNT_IDX_W-1:0] C_RXERR   = 3'd2;
  localparam logic [CNT_IDX_W-1:0] C_ECHOREP = 3'd3;
  localparam logic [CNT_IDX_W-1:0] C_UNREACH = 3'd4;
  localparam logic [CNT_IDX_W-1:0] C_TIMEEXC = 3'd5;
  localparam logic [CNT_IDX_W-1:0] C_REDIR   = 3'd6;

  localparam int OUT_FIELDS_W = 1 + IP_W + 1 + RLEN_W + N_CNT * CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // actions
  localparam logic [ACT_W-1:0] ACT_RX    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // icmp types
  localparam logic [TYPE_W-1:0] T_ECHO_REPLY = 8'd0;
  localparam logic [TYPE_W-1:0] T_UNREACH    = 8'd3;
  localparam logic [TYPE_W-1:0] T_REDIRECT   = 8'd5;
  localparam logic [TYPE_W-1:0] T_ECHO_REQ   = 8'd8;
  localparam logic [TYPE_W-1:0] T_TIME_EXC   = 8'd11;

  // length limits
  localparam logic [LEN_W-1:0] MIN_LEN   = 12'd8;
  localparam logic [LEN_W-1:0] MAX_LEN   = 12'd2048;
  localparam logic [LEN_W-1:0] REPLY_CAP = 12'd512;

  typedef logic [N_CNT-1:0][CNT_W-1:0] cnt_vec_t;

  typedef struct packed {
    logic                 bump;
    logic [CNT_IDX_W-1:0] idx;
    logic                 clear;
  } stat_cmd_t;

endpackage

// ----- rtl/icmp_rcrm_ram.sv -----
`timescale 1ns / 1ps

module icmp_rcrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/icmp_rcrm_stats.sv -----
`timescale 1ns / 1ps

module icmp_rcrm_stats
  import icmp_rcrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stat_cmd_t cmd,
  output cnt_vec_t  cnt
);

  cnt_vec_t         cnt_r;
  logic [CNT_W-1:0] sel;
  logic [CNT_W-1:0] inc;

  // one incrementer shared by all counters
  always_comb begin
    sel = '0;
    for (int i = 0; i < N_CNT; i++) begin
      if (cmd.idx == CNT_IDX_W'(i)) begin
        sel = cnt_r[i];
      end
    end
    inc = sel + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clear) begin
      cnt_r <= '0;
    end else if (cmd.bump) begin
      for (int i = 0; i < N_CNT; i++) begin
        if (cmd.idx == CNT_IDX_W'(i)) begin
          cnt_r[i] <= inc;
        end
      end
    end
  end

  assign cnt = cnt_r;

endmodule

// ----- rtl/icmp_receive_classify_reply_match.sv -----
// ICMP receive classifier with an echo-reply match ring. Each input word carries an
// action in in_tuser (receive, match query, clear statistics) and yields exactly one
// result word with the flags, the matched source and all seven statistics counters as
// they stand after the word. Counting goes one counter per cycle through a single
// shared incrementer. A valid receive passes through decode and classify; a receive with
// a bad length, a clear or an unused action goes straight from decode to the result. A
// match query walks the ring entries (at most QUEUE_DEPTH-1) until it stops on a match
// or finds none: each entry costs one registered read of the ring memory and one id/seq
// compare. in_tready is high only while no word is being worked on; a finished result
// waits in the output register and holds up the next word only once that word itself
// is finished, and then for as long as out_tready stays low.
`timescale 1ns / 1ps

module icmp_receive_classify_reply_match
  import icmp_rcrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // msg_len[11:0], msg_type[19:12], msg_id[35:20], msg_seq[51:36], src_ip[83:52]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // found[0], matched_src_ip[32:1], send_reply[33], echo_len[43:34],
  // count_rx[75:44], count_tx[107:76], count_rx_err[139:108],
  // count_echo_reply[171:140], count_unreach[203:172],
  // count_time_exceeded[235:204], count_redirect[267:236]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CLASS  = 3'd2;
  localparam logic [2:0] S_QRD    = 3'd3;
  localparam logic [2:0] S_QCMP   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  logic [2:0]            state_r, state_nxt;
  logic [ACT_W-1:0]      act_r, act_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [TYPE_W-1:0]     type_r, type_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [SEQ_W-1:0]      seq_r, seq_nxt;
  logic [IP_W-1:0]       src_r, src_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic                  found_r, found_nxt;
  logic [IP_W-1:0]       msrc_r, msrc_nxt;
  logic                  send_r, send_nxt;
  logic [RLEN_W-1:0]     rlen_r, rlen_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  stat_cmd_t             stat_cmd;
  cnt_vec_t              cnt;

  logic                  ram_we;
  logic                  ram_re;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;

  logic                  len_bad;
  logic                  ring_full;
  logic                  hit;

  icmp_rcrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (tail_r),
    .rdata (ram_rdata)
  );

  icmp_rcrm_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stat_cmd),
    .cnt   (cnt)
  );

  assign len_bad   = (len_r < MIN_LEN) || (len_r > MAX_LEN);
  assign ring_full = (ring_next(head_r) == tail_r);
  assign ram_wdata = {id_r, seq_r, src_r};
  // entry layout: id on top, then seq, then source
  assign hit       = (ram_rdata[ENTRY_W-1 -: ID_W] == id_r) &&
                     (ram_rdata[IP_W + SEQ_W - 1 -: SEQ_W] == seq_r);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    len_nxt       = len_r;
    type_nxt      = type_r;
    id_nxt        = id_r;
    seq_nxt       = seq_r;
    src_nxt       = src_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    found_nxt     = found_r;
    msrc_nxt      = msrc_r;
    send_nxt      = send_r;
    rlen_nxt      = rlen_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    stat_cmd      = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = in_tuser;
          len_nxt   = in_tdata[LEN_W-1:0];
          type_nxt  = in_tdata[19:12];
          id_nxt    = in_tdata[35:20];
          seq_nxt   = in_tdata[51:36];
          src_nxt   = in_tdata[83:52];
          found_nxt = 1'b0;
          msrc_nxt  = '0;
          send_nxt  = 1'b0;
          rlen_nxt  = '0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (act_r)
          ACT_RX: begin
            stat_cmd.bump = 1'b1;
            if (len_bad) begin
              stat_cmd.idx = C_RXERR;
              state_nxt    = S_DONE;
            end else begin
              stat_cmd.idx = C_RX;
              state_nxt    = S_CLASS;
            end
          end
          ACT_QUERY: state_nxt = S_QRD;
          ACT_CLEAR: begin
            stat_cmd.clear = 1'b1;
            state_nxt      = S_DONE;
          end
          default:   state_nxt = S_DONE;
        endcase
      end
      S_CLASS: begin
        state_nxt = S_DONE;
        unique case (type_r)
          T_ECHO_REQ: begin
            stat_cmd.bump = 1'b1;
            stat_cmd.idx  = C_TX;
            send_nxt      = 1'b1;
            rlen_nxt      = (len_r > REPLY_CAP) ? RLEN_W'(REPLY_CAP) : len_r[RLEN_W-1:0];
          end
          T_ECHO_REPLY: begin
            stat_cmd.bump = 1'b1;
            stat_cmd.idx  = C_ECHOREP;
            // full ring drops the entry but still counts it
            if (!ring_full) begin
              ram_we   = 1'b1;
              head_nxt = ring_next(head_r);
            end
          end
          T_UNREACH: begin
            stat_cmd.bump = 1'b1;
            stat_cmd.idx  = C_UNREACH;
          end
          T_TIME_EXC: begin
            stat_cmd.bump = 1'b1;
            stat_cmd.idx  = C_TIMEEXC;
          end
          T_REDIRECT: begin
            stat_cmd.bump = 1'b1;
            stat_cmd.idx  = C_REDIR;
          end
          default: ;
        endcase
      end
      S_QRD: begin
        if (tail_r == head_r) begin
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_QCMP;
        end
      end
      S_QCMP: begin
        // entry is consumed whether it matches or not
        tail_nxt = ring_next(tail_r);
        if (hit) begin
          found_nxt = 1'b1;
          msrc_nxt  = ram_rdata[IP_W-1:0];
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_QRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                           cnt[C_REDIR], cnt[C_TIMEEXC], cnt[C_UNREACH],
                           cnt[C_ECHOREP], cnt[C_RXERR], cnt[C_TX], cnt[C_RX],
                           rlen_r, send_r, msrc_r, found_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    len_r      <= len_nxt;
    type_r     <= type_nxt;
    id_r       <= id_nxt;
    seq_r      <= seq_nxt;
    src_r      <= src_nxt;
    found_r    <= found_nxt;
    msrc_r     <= msrc_nxt;
    send_r     <= send_nxt;
    rlen_r     <= rlen_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/icmp_rcrm_checker.sv -----
`timescale 1ns / 1ps

module icmp_rcrm_checker
  import icmp_rcrm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // block is busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after accept");

  // no source without a match
  a_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == '0)
    else $error("matched source set without match");

  // reply length only with a reply, and capped
  a_rlen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33] || out_tdata[43:34] == '0) &&
                   (out_tdata[43:34] <= 10'd512))
    else $error("bad reply length");

  // a word never has both found and send_reply set
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[33]))
    else $error("found and send_reply both set");

endmodule

bind icmp_receive_classify_reply_match icmp_rcrm_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- bench/icmp_reply_match_checker.sv -----
`timescale 1ns / 1ps

module icmp_reply_match_checker
  import icmp_rcrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // msg_len, msg_type, msg_id, msg_seq, src_ip
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic [ACT_W-1:0]      in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // found, matched_src_ip, send_reply, echo_len, seven counters
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int unsigned           fail_count,
  output int unsigned           results_due
);

  typedef struct packed {
    logic [IP_W-1:0]   src_ip;
    logic [SEQ_W-1:0]  seq;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] typ;
    logic [LEN_W-1:0]  len;
  } icmp_msg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  redirect;
    logic [CNT_W-1:0]  time_exc;
    logic [CNT_W-1:0]  unreach;
    logic [CNT_W-1:0]  echo_rep;
    logic [CNT_W-1:0]  rx_err;
    logic [CNT_W-1:0]  tx;
    logic [CNT_W-1:0]  rx;
    logic [RLEN_W-1:0] echo_len;
    logic              send_reply;
    logic [IP_W-1:0]   matched_src;
    logic              found;
  } status_word_t;

  // shadow copy of the pending reply ring and the counters
  logic [ID_W-1:0]  ring_id  [QUEUE_DEPTH];
  logic [SEQ_W-1:0] ring_seq [QUEUE_DEPTH];
  logic [IP_W-1:0]  ring_src [QUEUE_DEPTH];
  logic [PTR_W-1:0] ring_head;
  logic [PTR_W-1:0] ring_tail;
  cnt_vec_t         stats;

  status_word_t due_words[$];

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic status_word_t classify_and_match(logic [ACT_W-1:0] act, icmp_msg_t m);
    status_word_t w;
    logic [PTR_W-1:0] nx;
    w = '0;
    case (act)
      ACT_RX: begin
        if (m.len < MIN_LEN || m.len > MAX_LEN) begin
          stats[C_RXERR] = stats[C_RXERR] + 1;
        end else begin
          stats[C_RX] = stats[C_RX] + 1;
          case (m.typ)
            T_ECHO_REQ: begin
              w.send_reply = 1'b1;
              w.echo_len   = RLEN_W'((m.len > REPLY_CAP) ? REPLY_CAP : m.len);
              stats[C_TX]  = stats[C_TX] + 1;
            end
            T_ECHO_REPLY: begin
              stats[C_ECHOREP] = stats[C_ECHOREP] + 1;
              nx = ring_next(ring_head);
              // full ring keeps one slot free, the reply is counted but dropped
              if (nx != ring_tail) begin
                ring_id[ring_head]  = m.id;
                ring_seq[ring_head] = m.seq;
                ring_src[ring_head] = m.src_ip;
                ring_head = nx;
              end
            end
            T_UNREACH:  stats[C_UNREACH] = stats[C_UNREACH] + 1;
            T_TIME_EXC: stats[C_TIMEEXC] = stats[C_TIMEEXC] + 1;
            T_REDIRECT: stats[C_REDIR]   = stats[C_REDIR] + 1;
            default: ;
          endcase
        end
      end
      ACT_QUERY: begin
        // entries ahead of the match are thrown away
        while (ring_tail != ring_head && !w.found) begin
          if (ring_id[ring_tail] == m.id && ring_seq[ring_tail] == m.seq) begin
            w.found       = 1'b1;
            w.matched_src = ring_src[ring_tail];
          end
          ring_tail = ring_next(ring_tail);
        end
      end
      ACT_CLEAR: stats = '0;
      default: ;
    endcase
    w.rx       = stats[C_RX];
    w.tx       = stats[C_TX];
    w.rx_err   = stats[C_RXERR];
    w.echo_rep = stats[C_ECHOREP];
    w.unreach  = stats[C_UNREACH];
    w.time_exc = stats[C_TIMEEXC];
    w.redirect = stats[C_REDIR];
    return w;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    status_word_t want;
    status_word_t got;
    if (!rst_n) begin
      ring_head = '0;
      ring_tail = '0;
      stats     = '0;
      due_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_FIELDS_W-1:0];
        if (due_words.size() == 0) begin
          $error("result word with no prediction waiting: %0h", out_tdata);
          fail_count++;
        end else begin
          want = due_words.pop_front();
          check_field("found", CNT_W'(want.found), CNT_W'(got.found));
          check_field("matched_src_ip", want.matched_src, got.matched_src);
          check_field("send_reply", CNT_W'(want.send_reply), CNT_W'(got.send_reply));
          check_field("echo_len", CNT_W'(want.echo_len), CNT_W'(got.echo_len));
          check_field("count_rx", want.rx, got.rx);
          check_field("count_tx", want.tx, got.tx);
          check_field("count_rx_err", want.rx_err, got.rx_err);
          check_field("count_echo_reply", want.echo_rep, got.echo_rep);
          check_field("count_unreach", want.unreach, got.unreach);
          check_field("count_time_exceeded", want.time_exc, got.time_exc);
          check_field("count_redirect", want.redirect, got.redirect);
        end
      end
      if (in_tvalid && in_tready)
        due_words.push_back(classify_and_match(in_tuser, in_tdata[IN_FIELDS_W-1:0]));
    end
    results_due = due_words.size();
  end

endmodule

// ----- bench/tb_icmp_receive_classify_reply_match.sv -----
`timescale 1ns / 1ps

module tb_icmp_receive_classify_reply_match;
  import icmp_rcrm_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned      ITEM_GOAL  = 1150;
  localparam int unsigned      DRAIN_WAIT = 40;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // msg_len[11:0], msg_type[19:12], msg_id[35:20], msg_seq[51:36], src_ip[83:52]
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // action[1:0]
  logic [ACT_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // found[0], matched_src_ip[32:1], send_reply[33], echo_len[43:34], counters above
  logic [OUT_DATA_W-1:0] out_tdata;

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned burst_left;
  int unsigned sent_items;
  logic        random_phase = 1'b0;
  logic        backpressure_done = 1'b0;
  logic [31:0] echo_keys[$];

  always #6 clk = ~clk;

  icmp_receive_classify_reply_match dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  icmp_reply_match_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  function automatic logic [IN_DATA_W-1:0] pack_msg(logic [LEN_W-1:0] len,
      logic [TYPE_W-1:0] typ, logic [ID_W-1:0] id, logic [SEQ_W-1:0] seq,
      logic [IP_W-1:0] src);
    return IN_DATA_W'({src, seq, id, typ, len});
  endfunction

  function automatic logic [TYPE_W-1:0] pick_type();
    case ($urandom_range(0, 6))
      0: return T_ECHO_REQ;
      1: return T_ECHO_REPLY;
      2: return T_UNREACH;
      3: return T_TIME_EXC;
      4: return T_REDIRECT;
      default: return TYPE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] any_len();
    return LEN_W'($urandom_range(0, 4095));
  endfunction

  function automatic logic [LEN_W-1:0] good_len();
    // short lengths often, so the reply cap is hit both ways
    if ($urandom_range(0, 1) == 0)
      return LEN_W'($urandom_range(MIN_LEN, REPLY_CAP + 8));
    return LEN_W'($urandom_range(MIN_LEN, MAX_LEN));
  endfunction

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [IN_DATA_W-1:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    if (act != ACT_UNUSED)
      sent_items++;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_misc();
    send_word(ACT_RX, pack_msg(good_len(), pick_type(), ID_W'($urandom_range(0, 65535)),
                               SEQ_W'($urandom_range(0, 65535)), $urandom()));
  endtask

  // echo replies followed by the queries that retire them
  task automatic ping_run();
    int unsigned n;
    logic [31:0] key;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
    echo_keys.delete();
    repeat (n) begin
      key = $urandom();
      echo_keys.push_back(key);
      send_word(ACT_RX, pack_msg(good_len(), T_ECHO_REPLY, key[31:16], key[15:0],
                                 $urandom()));
      if ($urandom_range(0, 4) == 0)
        send_misc();
    end
    while (echo_keys.size() > 0) begin
      key = ($urandom_range(0, 7) == 0) ? echo_keys.pop_back() : echo_keys.pop_front();
      case ($urandom_range(0, 7))
        0: ;
        1: send_word(ACT_QUERY, pack_msg(any_len(), pick_type(), key[31:16] ^ 16'h1,
                                         key[15:0], $urandom()));
        default: send_word(ACT_QUERY, pack_msg(any_len(), pick_type(), key[31:16],
                                               key[15:0], $urandom()));
      endcase
      if ($urandom_range(0, 5) == 0)
        send_misc();
    end
  endtask

  task automatic noise_run();
    repeat ($urandom_range(4, 12))
      send_word(ACT_W'($urandom_range(0, 3)),
                pack_msg(any_len(), pick_type(), ID_W'($urandom_range(0, 65535)),
                         SEQ_W'($urandom_range(0, 65535)), $urandom()));
  endtask

  // replies with bad lengths never enter the ring, so their queries miss
  task automatic broken_run();
    logic [31:0] key;
    repeat ($urandom_range(1, 5)) begin
      key = $urandom();
      send_word(ACT_RX, pack_msg(($urandom_range(0, 1) == 0) ? LEN_W'($urandom_range(0, 7))
                                   : LEN_W'($urandom_range(MAX_LEN + 1, 4095)),
                                 T_ECHO_REPLY, key[31:16], key[15:0], $urandom()));
      send_word(ACT_QUERY, pack_msg(any_len(), pick_type(), key[31:16], key[15:0],
                                    $urandom()));
    end
  endtask

  // receiver: stall pattern of its own, plus one long hold-off
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    tick = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (random_phase && !backpressure_done) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        backpressure_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 0);
          2: out_tready <= (tick % 3 == 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  initial begin
    burst_left = $urandom_range(0, 30);
    sent_items = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // length limits
    send_word(ACT_RX, pack_msg(12'd0, T_ECHO_REQ, 16'h0001, 16'h0001, 32'h0a000001));
    send_word(ACT_RX, pack_msg(12'd7, T_ECHO_REPLY, 16'h0002, 16'h0002, 32'h0a000002));
    send_word(ACT_RX, pack_msg(12'd2049, T_UNREACH, 16'h0003, 16'h0003, 32'h0a000003));
    send_word(ACT_RX, pack_msg(12'hfff, 8'hff, 16'hffff, 16'hffff, 32'hffffffff));
    // echo requests around the reply cap
    send_word(ACT_RX, pack_msg(12'd8, T_ECHO_REQ, 16'h1234, 16'h0000, 32'hc0a80001));
    send_word(ACT_RX, pack_msg(12'd512, T_ECHO_REQ, 16'h1234, 16'h0001, 32'hc0a80001));
    send_word(ACT_RX, pack_msg(12'd513, T_ECHO_REQ, 16'h1234, 16'h0002, 32'hc0a80001));
    send_word(ACT_RX, pack_msg(12'd2048, T_ECHO_REQ, 16'h1234, 16'h0003, 32'hc0a80001));
    // echo replies into the ring
    send_word(ACT_RX, pack_msg(12'd64, T_ECHO_REPLY, 16'h0001, 16'h0001, 32'h01020304));
    send_word(ACT_RX, pack_msg(12'd64, T_ECHO_REPLY, 16'h0002, 16'h0002, 32'h05060708));
    send_word(ACT_RX, pack_msg(12'd8, T_ECHO_REPLY, 16'hffff, 16'hffff, 32'hffffffff));
    // other classes and an unknown type
    send_word(ACT_RX, pack_msg(12'd36, T_UNREACH, 16'h0000, 16'h0000, 32'h08080808));
    send_word(ACT_RX, pack_msg(12'd36, T_TIME_EXC, 16'h0000, 16'h0000, 32'h08080404));
    send_word(ACT_RX, pack_msg(12'd36, T_REDIRECT, 16'h0000, 16'h0000, 32'h08080202));
    send_word(ACT_RX, pack_msg(12'd100, 8'hff, 16'h5555, 16'haaaa, 32'h55aa55aa));
    // match after a discard, then a miss that empties the ring, then an empty query
    send_word(ACT_QUERY, pack_msg(12'd0, 8'd0, 16'h0002, 16'h0002, 32'h0));
    send_word(ACT_QUERY, pack_msg(12'hfff, 8'hff, 16'hffff, 16'h0000, 32'hffffffff));
    send_word(ACT_QUERY, pack_msg(12'd0, 8'd0, 16'h0001, 16'h0001, 32'h0));
    send_word(ACT_UNUSED, pack_msg(12'd64, T_ECHO_REPLY, 16'h0007, 16'h0007, 32'h7));
    send_word(ACT_CLEAR, pack_msg(12'd64, T_ECHO_REQ, 16'h0, 16'h0, 32'h0));
    send_word(ACT_RX, pack_msg(12'd2048, T_ECHO_REPLY, 16'h0000, 16'h0000, 32'h00000000));
    send_word(ACT_QUERY, pack_msg(12'd0, 8'd0, 16'h0000, 16'h0000, 32'h0));
    send_word(ACT_UNUSED, pack_msg(12'hfff, 8'hff, 16'hffff, 16'hffff, 32'hffffffff));

    random_phase = 1'b1;
    while (sent_items < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: ping_run();
        6, 7: noise_run();
        8: send_word(ACT_CLEAR, pack_msg(any_len(), pick_type(),
                                         ID_W'($urandom_range(0, 65535)),
                                         SEQ_W'($urandom_range(0, 65535)), $urandom()));
        default: broken_run();
      endcase
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (results_due != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
